// ----- hdl/cdf97_pkg.sv -----
package cdf97_pkg;

	localparam int MAX_LEN_DEF = 64;

	localparam int LEN_W      = 7;
	localparam int POS_W      = 6;
	localparam int SAMPLE_W   = 16;
	localparam int FRAC       = 16;
	localparam int STORE_W    = 40;
	localparam int SUM_W      = STORE_W + 1;
	localparam int COEF_W     = 18;
	localparam int PROD_W     = SUM_W + COEF_W;
	localparam int OUT_W      = 24;
	localparam int OUT_SHIFT  = 28;
	localparam int TERM_W     = PROD_W + 1 - FRAC;
	localparam int LSUM_W     = TERM_W + 1;
	localparam int SCALED_W   = PROD_W + 1 - OUT_SHIFT;

	localparam int PADDR_W    = 3;
	localparam int PDATA_W    = 32;

	localparam logic [0:0]       REG_LINE_LENGTH = 1'b0;
	localparam logic [LEN_W-1:0] LEN_RESET       = LEN_W'(64);
	localparam logic [LEN_W-1:0] LEN_MIN         = LEN_W'(4);

	localparam logic signed [COEF_W-1:0] C_A1   = -18'sd103949;
	localparam logic signed [COEF_W-1:0] C_A2   = -18'sd3472;
	localparam logic signed [COEF_W-1:0] C_A3   = 18'sd57862;
	localparam logic signed [COEF_W-1:0] C_A4   = 18'sd29066;
	localparam logic signed [COEF_W-1:0] C_K    = 18'sd75340;
	localparam logic signed [COEF_W-1:0] C_INVK = 18'sd57007;

	localparam logic [1:0] LAST_PASS = 2'd3;

	localparam logic signed [PROD_W:0] LIFT_RND  = (PROD_W + 1)'(1) << (FRAC - 1);
	localparam logic signed [PROD_W:0] SCALE_RND = (PROD_W + 1)'(1) << (OUT_SHIFT - 1);

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_PRE_RD,
		ST_PRE_LD,
		ST_RD,
		ST_SUM,
		ST_MUL,
		ST_WB,
		ST_ORD,
		ST_OMUL,
		ST_ORES
	} state_t;

	function automatic logic signed [COEF_W-1:0] lift_coef(input logic [1:0] pass);
		logic signed [COEF_W-1:0] c;
		case (pass)
			2'd0:    c = C_A1;
			2'd1:    c = C_A2;
			2'd2:    c = C_A3;
			default: c = C_A4;
		endcase
		return c;
	endfunction

endpackage

// ----- hdl/cdf97_mul.sv -----
module cdf97_mul (
	input  logic                                 clk,
	input  logic                                 en,
	input  logic signed [cdf97_pkg::SUM_W-1:0]   a,
	input  logic signed [cdf97_pkg::COEF_W-1:0]  b,
	output logic signed [cdf97_pkg::PROD_W-1:0]  p
);
	import cdf97_pkg::*;

	logic signed [PROD_W-1:0] p_q;

	always_ff @(posedge clk) begin
		if (en) begin
			p_q <= PROD_W'(a * b);
		end
	end

	assign p = p_q;

endmodule

// ----- hdl/cdf97_engine.sv -----
module cdf97_engine #(
	parameter int MAX_LEN = cdf97_pkg::MAX_LEN_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic [cdf97_pkg::LEN_W-1:0]           line_len,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [cdf97_pkg::SAMPLE_W-1:0] sample,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [cdf97_pkg::OUT_W-1:0]    coefficient,
	output logic                                  is_detail,
	output logic [cdf97_pkg::POS_W-1:0]           position,
	output logic                                  last
);
	import cdf97_pkg::*;

	localparam int AW = $clog2(MAX_LEN);
	localparam logic [LEN_W-1:0] MAX_LEN_L = LEN_W'(MAX_LEN);
	localparam logic signed [STORE_W-1:0] STORE_MAX = {1'b0, {(STORE_W - 1){1'b1}}};
	localparam logic signed [STORE_W-1:0] STORE_MIN = {1'b1, {(STORE_W - 1){1'b0}}};
	localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W - 1){1'b1}}};
	localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W - 1){1'b0}}};

	logic signed [STORE_W-1:0] mem [MAX_LEN];

	state_t state_q, state_d;
	logic [LEN_W-1:0] lc_q;
	logic [1:0]       pass_q;
	logic [AW-1:0]    i_q;
	logic [AW-1:0]    oaddr_q;
	logic [POS_W-1:0] opos_q;
	logic             out_valid_q;

	logic signed [STORE_W-1:0] rda_q, rdb_q, l_q, x_q;
	logic signed [SUM_W-1:0]   sum_q;
	logic signed [OUT_W-1:0]   coefficient_q;
	logic                      is_detail_q;
	logic [POS_W-1:0]          position_q;
	logic                      last_q;

	logic [AW-1:0]             rd_a_addr, rd_b_addr, wr_addr;
	logic                      wr_en;
	logic signed [STORE_W-1:0] wr_data;
	logic                      mul_en;
	logic signed [SUM_W-1:0]   mul_a;
	logic signed [COEF_W-1:0]  mul_b;
	logic signed [PROD_W-1:0]  mul_p;

	logic                      in_acc, line_done, out_free;
	logic [LEN_W-1:0]          lc_base, lc_inc, i_ext;
	logic                      is_pred, last_elem, edge_l, edge_r, olast;
	logic [AW-1:0]             i_nxt, oaddr_nxt;
	logic signed [STORE_W-1:0] ll, rr, sample_q16, lift_res;
	logic signed [PROD_W:0]    lift_rnd, scale_rnd;
	logic signed [TERM_W-1:0]  lift_term;
	logic signed [LSUM_W-1:0]  lift_sum;
	logic signed [SCALED_W-1:0] scaled;
	logic signed [OUT_W-1:0]   scale_res;

	cdf97_mul u_mul (
		.clk (clk),
		.en  (mul_en),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	assign in_acc     = in_valid && in_ready;
	assign lc_base    = (lc_q >= MAX_LEN_L) ? '0 : lc_q;
	assign lc_inc     = lc_base + LEN_W'(1);
	assign line_done  = lc_inc >= line_len;
	assign sample_q16 = {{(STORE_W - SAMPLE_W - FRAC){sample[SAMPLE_W-1]}}, sample, FRAC'(0)};

	assign is_pred   = ~pass_q[0];
	assign i_ext     = LEN_W'(i_q);
	assign edge_r    = is_pred && (i_ext == line_len - LEN_W'(1));
	assign edge_l    = !is_pred && (i_q == '0);
	assign last_elem = is_pred ? (i_ext == line_len - LEN_W'(1))
	                           : (i_ext == line_len - LEN_W'(2));
	assign rr        = edge_r ? l_q : rdb_q;
	assign ll        = edge_l ? rdb_q : l_q;
	assign i_nxt     = i_q + AW'(2);

	assign lift_rnd  = {mul_p[PROD_W-1], mul_p} + LIFT_RND;
	assign lift_term = lift_rnd[PROD_W:FRAC];
	assign lift_sum  = {{(LSUM_W - STORE_W){x_q[STORE_W-1]}}, x_q}
	                 + {lift_term[TERM_W-1], lift_term};
	always_comb begin
		if (&lift_sum[LSUM_W-1:STORE_W-1] || ~|lift_sum[LSUM_W-1:STORE_W-1]) begin
			lift_res = lift_sum[STORE_W-1:0];
		end else if (lift_sum[LSUM_W-1]) begin
			lift_res = STORE_MIN;
		end else begin
			lift_res = STORE_MAX;
		end
	end

	assign scale_rnd = {mul_p[PROD_W-1], mul_p} + SCALE_RND;
	assign scaled    = scale_rnd[PROD_W:OUT_SHIFT];
	always_comb begin
		if (&scaled[SCALED_W-1:OUT_W-1] || ~|scaled[SCALED_W-1:OUT_W-1]) begin
			scale_res = scaled[OUT_W-1:0];
		end else if (scaled[SCALED_W-1]) begin
			scale_res = OUT_MIN;
		end else begin
			scale_res = OUT_MAX;
		end
	end

	assign olast     = LEN_W'(opos_q) == line_len - LEN_W'(1);
	assign oaddr_nxt = (LEN_W'(oaddr_q) == line_len - LEN_W'(2)) ? AW'(1) : oaddr_q + AW'(2);
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD: begin
				if (in_acc && line_done) begin
					state_d = ST_PRE_RD;
				end
			end
			ST_PRE_RD: state_d = ST_PRE_LD;
			ST_PRE_LD: state_d = ST_SUM;
			ST_RD:     state_d = ST_SUM;
			ST_SUM:    state_d = ST_MUL;
			ST_MUL:    state_d = ST_WB;
			ST_WB: begin
				if (!last_elem) begin
					state_d = ST_SUM;
				end else if (pass_q == LAST_PASS) begin
					state_d = ST_ORD;
				end else if (pass_q[0]) begin
					state_d = ST_PRE_RD;
				end else begin
					state_d = ST_RD;
				end
			end
			ST_ORD:  state_d = ST_OMUL;
			ST_OMUL: state_d = ST_ORES;
			ST_ORES: begin
				if (out_free) begin
					state_d = olast ? ST_LOAD : ST_OMUL;
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		wr_en     = 1'b0;
		wr_addr   = i_q;
		wr_data   = lift_res;
		rd_a_addr = i_q;
		rd_b_addr = i_q + AW'(1);
		mul_en    = 1'b0;
		mul_a     = sum_q;
		mul_b     = lift_coef(pass_q);
		case (state_q)
			ST_LOAD: begin
				in_ready = 1'b1;
				wr_en    = in_acc;
				wr_addr  = lc_base[AW-1:0];
				wr_data  = sample_q16;
			end
			ST_PRE_RD: rd_a_addr = '0;
			ST_MUL:    mul_en = 1'b1;
			ST_WB: begin
				wr_en     = 1'b1;
				rd_a_addr = i_nxt;
				rd_b_addr = i_nxt + AW'(1);
			end
			ST_ORD: rd_a_addr = oaddr_q;
			ST_OMUL: begin
				mul_en = 1'b1;
				mul_a  = {rda_q[STORE_W-1], rda_q};
				mul_b  = oaddr_q[0] ? C_INVK : C_K;
			end
			ST_ORES: rd_a_addr = oaddr_nxt;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			lc_q        <= '0;
			pass_q      <= '0;
			i_q         <= '0;
			oaddr_q     <= '0;
			opos_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						lc_q <= line_done ? '0 : lc_inc;
						if (line_done) begin
							pass_q <= '0;
							i_q    <= AW'(1);
						end
					end
				end
				ST_WB: begin
					if (!last_elem) begin
						i_q <= i_nxt;
					end else begin
						pass_q  <= pass_q + 2'd1;
						i_q     <= pass_q[0] ? AW'(1) : '0;
						oaddr_q <= '0;
						opos_q  <= '0;
					end
				end
				ST_ORES: begin
					if (out_free && !olast) begin
						oaddr_q <= oaddr_nxt;
						opos_q  <= opos_q + POS_W'(1);
					end
				end
				default: ;
			endcase
			if (state_q == ST_ORES && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rda_q <= mem[rd_a_addr];
		rdb_q <= mem[rd_b_addr];
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (state_q == ST_PRE_LD) begin
			l_q <= rda_q;
		end
		if (state_q == ST_SUM) begin
			x_q   <= rda_q;
			sum_q <= {ll[STORE_W-1], ll} + {rr[STORE_W-1], rr};
			l_q   <= rr;
		end
		if (state_q == ST_ORES && out_free) begin
			coefficient_q <= scale_res;
			is_detail_q   <= oaddr_q[0];
			position_q    <= opos_q;
			last_q        <= olast;
		end
	end

	assign out_valid   = out_valid_q;
	assign coefficient = coefficient_q;
	assign is_detail   = is_detail_q;
	assign position    = position_q;
	assign last        = last_q;

`ifndef NO_ASSERTIONS
	a_wr_states: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == ST_LOAD || state_q == ST_WB))
		else $error("Store written outside of a load or write-back cycle.");

	a_parity: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SUM || state_q == ST_MUL || state_q == ST_WB) |-> (i_q[0] != pass_q[0]))
		else $error("Lifting index has the wrong parity for the current pass.");

	a_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WB && last_elem && pass_q == LAST_PASS) |=> (state_q == ST_ORD))
		else $error("Output phase did not follow the final lifting pass.");

	a_line_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ORES && out_free && olast) |=> (state_q == ST_LOAD && lc_q == '0))
		else $error("Block did not return to loading after the final coefficient.");

	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_ORES))
		else $error("Output became valid without a result stage.");
`endif

endmodule

// ----- hdl/cdf97_forward_lifting_step_top.sv -----
// One level of the CDF 9/7 forward lifting wavelet over a line of n signed 16-bit samples,
// where n is the line_length register with bit 0 cleared and clamped to 4..MAX_LEN rounded
// down to even. Samples are taken one per cycle while loading into a line store; the
// transaction carrying the last sample of a line starts the transform, which runs four
// lifting passes (each lift goes through the single shared 41x18 multiplier path), then
// emits n coefficients, each via a multiply state and a result state, low-pass half first.
// While the transform runs the input is not ready. Coefficients are Q4 values saturated
// to 24 bits; the output register lets the next line load while the last coefficient waits.
module cdf97_forward_lifting_step_top #(
	parameter int MAX_LEN = cdf97_pkg::MAX_LEN_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [cdf97_pkg::PADDR_W-1:0]         paddr,
	input  logic [cdf97_pkg::PDATA_W-1:0]         pwdata,
	output logic [cdf97_pkg::PDATA_W-1:0]         prdata,
	output logic                                  pready,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [cdf97_pkg::SAMPLE_W-1:0] sample,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [cdf97_pkg::OUT_W-1:0]    coefficient,
	output logic                                  is_detail,
	output logic [cdf97_pkg::POS_W-1:0]           position,
	output logic                                  last
);
	import cdf97_pkg::*;

	localparam logic [LEN_W-1:0] LEN_TOP = LEN_W'(MAX_LEN - (MAX_LEN % 2));

	logic [LEN_W-1:0] line_length_q;
	logic [LEN_W-1:0] len_even, line_len;
	logic             cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_length_q <= LEN_RESET;
		end else if (cfg_wr && paddr[PADDR_W-1:2] == REG_LINE_LENGTH) begin
			line_length_q <= pwdata[LEN_W-1:0];
		end
	end

	assign prdata = (paddr[PADDR_W-1:2] == REG_LINE_LENGTH) ? PDATA_W'(line_length_q) : '0;

	assign len_even = {line_length_q[LEN_W-1:1], 1'b0};

	always_comb begin
		if (len_even < LEN_MIN) begin
			line_len = LEN_MIN;
		end else if (len_even > LEN_TOP) begin
			line_len = LEN_TOP;
		end else begin
			line_len = len_even;
		end
	end

	cdf97_engine #(
		.MAX_LEN (MAX_LEN)
	) u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.line_len    (line_len),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.sample      (sample),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.coefficient (coefficient),
		.is_detail   (is_detail),
		.position    (position),
		.last        (last)
	);

endmodule
